// ===== rtl/multi_channel_periodic_timer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the periodic timer
// Implication checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PERIODIC_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_PERIODIC_TIMER_ASSERT_SVH
`ifndef SYNTHESIS
`define MCPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer assertion failed");
`define MCPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer assertion failed");
`else
`define MCPT_ASSERT_SAME(lbl, ante, cons)
`define MCPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/mcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpt_pkg
// Types and constants shared by the periodic timer modules.
// ----------------------------------------------------------------------------
package mcpt_pkg;

  localparam int MAX_CHANNELS = 4;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_LOAD    = 2'd0,
    REG_CURRENT = 2'd1,
    REG_CONTROL = 2'd2,
    REG_FLAG    = 2'd3
  } chan_reg_t;

  typedef enum logic {
    CFG_MODULE_DISABLE  = 1'b0,
    CFG_FREEZE_IN_DEBUG = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  address;
    logic [31:0] write_data;
    logic        debug_mode;
  } in_item_t;

  typedef struct packed {
    logic [31:0]             read_data;
    logic [MAX_CHANNELS-1:0] pending_flags;
    logic                    interrupt_request;
  } out_item_t;

  typedef struct packed {
    logic apply;
    logic capture;
  } ctl_cmd_t;

endpackage

// ===== rtl/mcpt_controller.sv =====
// ----------------------------------------------------------------------------
// mcpt_controller
// Handshake control: output register occupancy and item acceptance.
// ----------------------------------------------------------------------------
module mcpt_controller
  import mcpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctl_cmd_t cmd
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.apply   = accept;
    cmd.capture = accept;
    state_nxt   = state_r;
    case (state_r)
      ST_EMPTY: if (accept) state_nxt = ST_FULL;
      ST_FULL:  if (!accept && !out_stall) state_nxt = ST_EMPTY;
      default:  state_nxt = ST_EMPTY;
    endcase
    out_valid_nxt = (state_nxt == ST_FULL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/mcpt_datapath.sv =====
// ----------------------------------------------------------------------------
// mcpt_datapath
// Channel counters, register file, config bits and result register.
// ----------------------------------------------------------------------------
module mcpt_datapath
  import mcpt_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_cmd_t  cmd,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_wdata,
  output out_item_t out_data
);

  logic        mod_dis_r, frz_r;
  logic [31:0] load_r [CHANNELS];
  logic [31:0] load_nxt [CHANNELS];
  logic [31:0] cnt_r [CHANNELS];
  logic [31:0] cnt_nxt [CHANNELS];
  logic [CHANNELS-1:0] en_r, en_nxt, ie_r, ie_nxt, flg_r, flg_nxt;
  out_item_t   res_r, res_nxt;

  logic        mapped, tick_ok, is_rd, is_wr;
  logic [1:0]  ch;
  chan_reg_t   rsel;

  assign mapped  = in_data.address[8] && (in_data.address[7:6] == 2'b00);
  assign ch      = in_data.address[5:4];
  assign rsel    = chan_reg_t'(in_data.address[3:2]);
  assign tick_ok = cmd.apply && (in_data.kind == KIND_TICK) && !mod_dis_r
                   && !(frz_r && in_data.debug_mode);
  assign is_rd   = cmd.apply && (in_data.kind == KIND_READ);
  assign is_wr   = cmd.apply && (in_data.kind == KIND_WRITE);

  always_comb begin
    logic hit;
    res_nxt = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      hit         = mapped && (ch == 2'(c));
      load_nxt[c] = load_r[c];
      cnt_nxt[c]  = cnt_r[c];
      en_nxt[c]   = en_r[c];
      ie_nxt[c]   = ie_r[c];
      flg_nxt[c]  = flg_r[c];
      if (tick_ok && en_r[c]) begin
        if (cnt_r[c] == 32'd0) begin
          flg_nxt[c] = 1'b1;
          cnt_nxt[c] = load_r[c];
        end else begin
          cnt_nxt[c] = cnt_r[c] - 32'd1;
        end
      end
      if (is_wr && hit) begin
        case (rsel)
          REG_LOAD: load_nxt[c] = in_data.write_data;
          REG_CONTROL: begin
            if (in_data.write_data[0] && !en_r[c]) cnt_nxt[c] = load_r[c];
            en_nxt[c] = in_data.write_data[0];
            ie_nxt[c] = in_data.write_data[1];
          end
          REG_FLAG: if (in_data.write_data[0]) flg_nxt[c] = 1'b0;
          default: ;
        endcase
      end
      if (is_rd && hit) begin
        case (rsel)
          REG_LOAD:    res_nxt.read_data = load_r[c];
          REG_CURRENT: res_nxt.read_data = cnt_r[c];
          REG_CONTROL: res_nxt.read_data = {30'd0, ie_r[c], en_r[c]};
          default:     res_nxt.read_data = {31'd0, flg_r[c]};
        endcase
      end
      res_nxt.pending_flags[c] = flg_nxt[c];
      if (flg_nxt[c] && ie_nxt[c]) res_nxt.interrupt_request = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_dis_r <= 1'b1;
      frz_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MODULE_DISABLE:  mod_dis_r <= cfg_wdata;
        CFG_FREEZE_IN_DEBUG: frz_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        load_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
      en_r  <= '0;
      ie_r  <= '0;
      flg_r <= '0;
    end else if (cmd.apply) begin
      load_r <= load_nxt;
      cnt_r  <= cnt_nxt;
      en_r   <= en_nxt;
      ie_r   <= ie_nxt;
      flg_r  <= flg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) res_r <= res_nxt;
  end

  assign out_data = res_r;

endmodule

// ===== rtl/multi_channel_periodic_timer.sv =====
// ----------------------------------------------------------------------------
// multi_channel_periodic_timer
// Periodic interrupt timer with up to four down-counting channels.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries ticks, register reads and register writes as items; every
//   item yields exactly one result on out_* with read data (zero unless a
//   mapped read), the timeout flags and the combined interrupt request,
//   all taken after the item has been applied.
//   cfg_* sets module_disable (index 0) and freeze_in_debug (index 1); write
//   it only while no result is outstanding.
//   out_valid rises in the cycle after acceptance. Throughput: one item per
//   cycle while out_stall does not hold a waiting result, with all channel
//   counters updated together in the datapath and a one-deep output register.
//   Receiver stall: the result is held in the output register; a new item is
//   taken only in a cycle in which that register is free or being emptied,
//   so in_stall follows out_stall while a result waits.
//   Reset: counters, load values, enables and flags clear, module_disable
//   reads 1, freeze_in_debug 0, no result pending.
// ----------------------------------------------------------------------------
`include "multi_channel_periodic_timer_assert.svh"

module multi_channel_periodic_timer
  import mcpt_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_wdata
);

  ctl_cmd_t cmd;
  logic     item_acc;
  logic     non_read_acc;
  logic     irq_shown;

  mcpt_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mcpt_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

  assign item_acc     = in_valid && !in_stall;
  assign non_read_acc = item_acc && (in_data.kind != KIND_READ);
  assign irq_shown    = out_valid && out_data.interrupt_request;

  `MCPT_ASSERT_SAME(a_irq_has_flag, irq_shown, out_data.pending_flags != '0)
  `MCPT_ASSERT_NEXT(a_non_read_zero, non_read_acc, out_data.read_data == 32'd0)
  `MCPT_ASSERT_NEXT(a_accept_shows, item_acc, out_valid)

endmodule
